[hw/rtl/fda_pkg.sv]
// ----------------------------------------------------------------------------
// fda_pkg: shared types and constants for the fixed-point decimal text unit
// Holds the sequencer state type and the ASCII codes the unit emits.
// ----------------------------------------------------------------------------
package fda_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_INT,
		ST_POINT,
		ST_FRAC,
		ST_TERM
	} state_t;

	// ASCII codes
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_POINT = 8'd46;
	localparam logic [7:0] CH_NUL   = 8'd0;

	// Width of the digit count register
	localparam int FRAC_CFG_W = 4;

endpackage

[hw/rtl/fixed_to_decimal_ascii_unit.sv]
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_unit: signed fixed-point to decimal ASCII text
// Converts one signed fixed-point number into its decimal text, one
// character per beat, integer part by shift-and-add-3, fraction by x10 steps.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive value and raise start; the beat is taken at a rising edge
//   with start high and busy low. busy falls as the terminator beat is shown.
//   Output: each character appears on char_code for one cycle with strobe
//   high. Order: '-' if negative, integer digits without leading zeros (none
//   when the magnitude is below one), then '.' and frac_digits fraction
//   digits (truncated) when frac_digits is nonzero, then a NUL with last high.
//   The receiver cannot stall; every strobe beat is taken.
//   Config: cfg_data is written into frac_digits on cfg_valid & cfg_ready;
//   cfg_ready is always high. Values above MAX_FRAC_DIGITS saturate. Write
//   only while busy is low.
//   Sequence: the double-dabble loop shifts in every integer bit, then the
//   sign slot, one slot per BCD digit (leading zeros are skipped silently),
//   the point when nd is nonzero, one slot per fraction digit and the
//   terminator. A new value is taken only once busy has fallen, that is
//   once the terminator of the previous value is on the output.
//   Reset: arst_n clears the sequencer, strobe and sets frac_digits to 2.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_unit #(
	parameter int INT_BITS        = 31,
	parameter int FRAC_BITS       = 32,
	parameter int MAX_FRAC_DIGITS = 9
) (
	input  logic        clk,
	input  logic        arst_n,
	// command channel
	input  logic        start,
	output logic        busy,
	input  logic [63:0] value,
	// result channel
	output logic        strobe,
	output logic [7:0]  char_code,
	output logic        last,
	// config channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [fda_pkg::FRAC_CFG_W-1:0] cfg_data
);

	// Derived sizes
	localparam int VW    = (1 + INT_BITS + FRAC_BITS >= 64) ? 64 : 1 + INT_BITS + FRAC_BITS;
	localparam int IW    = VW - FRAC_BITS;
	localparam int NDIG  = (IW * 30103) / 100000 + 1;
	localparam int BW    = 4 * NDIG;
	localparam int ND_W  = $clog2(MAX_FRAC_DIGITS + 1);
	localparam int CMAX  = (IW > NDIG) ? ((IW > MAX_FRAC_DIGITS) ? IW : MAX_FRAC_DIGITS)
	                                   : ((NDIG > MAX_FRAC_DIGITS) ? NDIG : MAX_FRAC_DIGITS);
	localparam int CW    = $clog2(CMAX + 1);

	fda_pkg::state_t state_q, state_d;

	logic [fda_pkg::FRAC_CFG_W-1:0] frac_digits_q;
	logic [IW-1:0]        ishift_q;
	logic [FRAC_BITS-1:0] fpart_q;
	logic [BW-1:0]        bcd_q;
	logic [CW-1:0]        cnt_q;
	logic [ND_W-1:0]      nd_q;
	logic                 neg_q;
	logic                 started_q;

	logic [7:0] char_code_q;
	logic       strobe_q;
	logic       last_q;

	logic       accept;
	logic [VW-1:0] raw;
	logic [VW-1:0] mag;
	logic [ND_W-1:0] nd_sat;
	logic [BW-1:0] bcd_adj;
	logic [3:0]  top_dig;
	logic [FRAC_BITS+3:0] fx10;
	logic        cnt_zero;

	logic [7:0] char_d;
	logic       strobe_d;
	logic       last_d;

	assign accept    = start && !busy;
	assign busy      = (state_q != fda_pkg::ST_IDLE);
	assign cfg_ready = 1'b1;
	assign strobe    = strobe_q;
	assign char_code = char_code_q;
	assign last      = last_q;

	// Magnitude of the sign-extended input
	assign raw = value[VW-1:0];
	assign mag = raw[VW-1] ? (~raw + {{(VW-1){1'b0}}, 1'b1}) : raw;

	// Saturated fraction digit count
	always_comb begin
		if (frac_digits_q > fda_pkg::FRAC_CFG_W'(MAX_FRAC_DIGITS)) begin
			nd_sat = ND_W'(MAX_FRAC_DIGITS);
		end else begin
			nd_sat = ND_W'(frac_digits_q);
		end
	end

	// Double-dabble adjust: add 3 to every BCD digit of 5 or more
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[4*i +: 4] >= 4'd5) begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
			end else begin
				bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
			end
		end
	end

	assign top_dig  = bcd_q[BW-1 -: 4];
	assign fx10     = {1'b0, fpart_q, 3'b000} + {3'b000, fpart_q, 1'b0};
	assign cnt_zero = (cnt_q == '0);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			fda_pkg::ST_IDLE:  if (accept) state_d = fda_pkg::ST_CONV;
			fda_pkg::ST_CONV:  if (cnt_zero) state_d = fda_pkg::ST_SIGN;
			fda_pkg::ST_SIGN:  state_d = fda_pkg::ST_INT;
			fda_pkg::ST_INT: begin
				if (cnt_zero) begin
					state_d = (nd_q != '0) ? fda_pkg::ST_POINT : fda_pkg::ST_TERM;
				end
			end
			fda_pkg::ST_POINT: state_d = fda_pkg::ST_FRAC;
			fda_pkg::ST_FRAC:  if (cnt_zero) state_d = fda_pkg::ST_TERM;
			fda_pkg::ST_TERM:  state_d = fda_pkg::ST_IDLE;
			default:           state_d = fda_pkg::ST_IDLE;
		endcase
	end

	// Character for this cycle
	always_comb begin
		char_d   = fda_pkg::CH_NUL;
		strobe_d = 1'b0;
		last_d   = 1'b0;
		case (state_q)
			fda_pkg::ST_SIGN: begin
				char_d   = fda_pkg::CH_MINUS;
				strobe_d = neg_q;
			end
			fda_pkg::ST_INT: begin
				char_d   = fda_pkg::CH_ZERO + {4'h0, top_dig};
				strobe_d = started_q || (top_dig != 4'd0);
			end
			fda_pkg::ST_POINT: begin
				char_d   = fda_pkg::CH_POINT;
				strobe_d = 1'b1;
			end
			fda_pkg::ST_FRAC: begin
				char_d   = fda_pkg::CH_ZERO + {4'h0, fx10[FRAC_BITS+3:FRAC_BITS]};
				strobe_d = 1'b1;
			end
			fda_pkg::ST_TERM: begin
				char_d   = fda_pkg::CH_NUL;
				strobe_d = 1'b1;
				last_d   = 1'b1;
			end
			default: begin
				char_d   = fda_pkg::CH_NUL;
				strobe_d = 1'b0;
				last_d   = 1'b0;
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= fda_pkg::ST_IDLE;
			frac_digits_q <= fda_pkg::FRAC_CFG_W'(2);
			strobe_q      <= 1'b0;
			last_q        <= 1'b0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
			last_q   <= last_d;
			if (cfg_valid && cfg_ready) begin
				frac_digits_q <= cfg_data;
			end
		end
	end

	// Datapath: digit loops and output character
	always_ff @(posedge clk) begin
		char_code_q <= char_d;
		case (state_q)
			fda_pkg::ST_IDLE: begin
				if (accept) begin
					ishift_q <= mag[VW-1:FRAC_BITS];
					fpart_q  <= mag[FRAC_BITS-1:0];
					neg_q    <= raw[VW-1];
					nd_q     <= nd_sat;
					bcd_q    <= '0;
					cnt_q    <= CW'(IW - 1);
				end
			end
			fda_pkg::ST_CONV: begin
				bcd_q    <= {bcd_adj[BW-2:0], ishift_q[IW-1]};
				ishift_q <= {ishift_q[IW-2:0], 1'b0};
				if (cnt_zero) begin
					cnt_q     <= CW'(NDIG - 1);
					started_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			fda_pkg::ST_INT: begin
				bcd_q     <= {bcd_q[BW-5:0], 4'h0};
				started_q <= started_q || (top_dig != 4'd0);
				if (!cnt_zero) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			fda_pkg::ST_POINT: begin
				cnt_q <= CW'(nd_q) - CW'(1);
			end
			fda_pkg::ST_FRAC: begin
				fpart_q <= fx10[FRAC_BITS-1:0];
				if (!cnt_zero) begin
					cnt_q <= cnt_q - CW'(1);
				end
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end

	// Assertions
	a_last_after_term: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> $past(state_q == fda_pkg::ST_TERM))
		else $error("last raised outside the terminator slot");

	a_busy_falls_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> (last_q && strobe_q))
		else $error("busy dropped without a terminator beat");

	a_start_enters_conv: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == fda_pkg::ST_CONV))
		else $error("accepted command did not start conversion");

	a_minus_only_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe_q && char_code_q == fda_pkg::CH_MINUS) |-> $past(neg_q))
		else $error("minus sign emitted for a non-negative value");

endmodule

[verif/fixed_to_decimal_ascii_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_to_decimal_ascii_unit_tb: self-checking bench for the decimal text unit
// Feeds signed Q31.32 numbers through the command port under several digit
// counts. A scoreboard builds each number's expected character string and
// compares every strobed character and its last flag against it in order.
// ----------------------------------------------------------------------------
module fixed_to_decimal_ascii_unit_tb;

	localparam int INT_BITS        = 31;
	localparam int FRAC_BITS       = 32;
	localparam int MAX_FRAC_DIGITS = 9;
	// cycles with no beat on any port before the run is called hung
	localparam int QUIET_LIMIT     = 2000;
	// settle time after the last character, about one full conversion
	localparam int END_SETTLE      = 60;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} text_beat_t;

	// Scoreboard: predicts the text of each accepted number, checks output order
	class decimal_text_scoreboard;
		logic [fda_pkg::FRAC_CFG_W-1:0] frac_digits;
		text_beat_t                     expected_chars[$];
		int                             errors;

		function new();
			frac_digits = 4'd2;
			errors      = 0;
		endfunction

		function void set_digits(logic [fda_pkg::FRAC_CFG_W-1:0] d);
			frac_digits = d;
		endfunction

		function int pending();
			return expected_chars.size();
		endfunction

		// Sign, integer digits, point, truncated fraction digits, terminator.
		// 1+INT_BITS+FRAC_BITS is 64 here, so bit 63 is the sign.
		function void predict_decimal_text(logic [63:0] v);
			logic                 neg;
			logic [63:0]          mag;
			logic [63:0]          ipart;
			logic [FRAC_BITS-1:0] fpart;
			logic [FRAC_BITS+3:0] scaled;
			logic [3:0]           int_digits [24];
			int                   n_int;
			int                   n_frac;
			neg    = v[63];
			mag    = neg ? (~v + 64'd1) : v;
			ipart  = mag >> FRAC_BITS;
			fpart  = mag[FRAC_BITS-1:0];
			n_frac = (frac_digits > MAX_FRAC_DIGITS) ? MAX_FRAC_DIGITS : int'(frac_digits);
			n_int  = 0;
			while (ipart != 64'd0) begin
				int_digits[n_int] = 4'(ipart % 64'd10);
				ipart = ipart / 64'd10;
				n_int++;
			end
			if (neg)
				expected_chars.push_back('{code: fda_pkg::CH_MINUS, last: 1'b0});
			for (int i = n_int - 1; i >= 0; i--)
				expected_chars.push_back('{code: fda_pkg::CH_ZERO + 8'(int_digits[i]),
					last: 1'b0});
			if (n_frac > 0) begin
				expected_chars.push_back('{code: fda_pkg::CH_POINT, last: 1'b0});
				for (int d = 0; d < n_frac; d++) begin
					scaled = {4'd0, fpart} * 36'd10;
					expected_chars.push_back('{code: fda_pkg::CH_ZERO +
						8'(scaled[FRAC_BITS+3:FRAC_BITS]), last: 1'b0});
					fpart = scaled[FRAC_BITS-1:0];
				end
			end
			expected_chars.push_back('{code: fda_pkg::CH_NUL, last: 1'b1});
		endfunction

		function void check_char(logic [7:0] code, logic last);
			text_beat_t exp_beat;
			if (expected_chars.size() == 0) begin
				$display("%0t: unexpected character: expected none, got %02h last %b",
					$time, code, last);
				errors++;
				return;
			end
			exp_beat = expected_chars.pop_front();
			if (code !== exp_beat.code) begin
				$display("%0t: char_code mismatch: expected %02h, got %02h",
					$time, exp_beat.code, code);
				errors++;
			end
			if (last !== exp_beat.last) begin
				$display("%0t: last mismatch: expected %b, got %b",
					$time, exp_beat.last, last);
				errors++;
			end
		endfunction

		function void check_drained();
			if (expected_chars.size() != 0) begin
				$display("%0t: %0d expected characters never arrived",
					$time, expected_chars.size());
				errors += expected_chars.size();
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [63:0]                    value;
	logic                           strobe;
	logic [7:0]                     char_code;
	logic                           last;
	logic                           cfg_valid;
	logic                           cfg_ready;
	logic [fda_pkg::FRAC_CFG_W-1:0] cfg_data;

	decimal_text_scoreboard sb = new();
	int                     quiet_cycles = 0;

	fixed_to_decimal_ascii_unit #(
		.INT_BITS        (INT_BITS),
		.FRAC_BITS       (FRAC_BITS),
		.MAX_FRAC_DIGITS (MAX_FRAC_DIGITS)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.strobe    (strobe),
		.char_code (char_code),
		.last      (last),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Result check and hang watchdog, sampled on the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				sb.check_char(char_code, last);
			if (strobe || (start && !busy) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
				$display("FAIL");
				$finish;
			end
		end
	end

	// One number beat; entered and left at a falling edge. Start stays high
	// across back-to-back beats when the gap is zero.
	task automatic send_value(input logic [63:0] v, input int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		value <= v;
		do @(posedge clk); while (busy);
		sb.predict_decimal_text(v);
		@(negedge clk);
	endtask

	// Drop start and wait for every character and for busy to clear
	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	task automatic write_frac_digits(input logic [fda_pkg::FRAC_CFG_W-1:0] d);
		cfg_valid <= 1'b1;
		cfg_data  <= d;
		do @(posedge clk); while (!cfg_ready);
		sb.set_digits(d);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic run_random_phase(input int n_items, input bit burst);
		logic [63:0] v;
		logic [31:0] ipart;
		int          kind;
		for (int i = 0; i < n_items; i++) begin
			kind  = $urandom_range(0, 5);
			ipart = $urandom;
			case (kind)
				0: v = {$urandom, $urandom};
				1: v = {32'(ipart % 1000), 32'($urandom)};
				2: v = {32'd0, 32'($urandom)};
				3: v = {ipart >> $urandom_range(0, 31), 32'd0};
				4: begin
					case ($urandom_range(0, 5))
						0: v = 64'd0;
						1: v = 64'h8000_0000_0000_0000;
						2: v = 64'h7FFF_FFFF_FFFF_FFFF;
						3: v = 64'hFFFF_FFFF_FFFF_FFFF;
						4: v = 64'h0000_0001_0000_0000;
						default: v = 64'hFFFF_FFFF_0000_0000;
					endcase
				end
				default: v = {ipart >> $urandom_range(0, 31), 32'($urandom)};
			endcase
			// mostly well-formed magnitudes, either sign
			if (kind != 0 && kind != 4 && $urandom_range(0, 1))
				v = -v;
			send_value(v, burst ? 0 : $urandom_range(0, 15));
		end
	endtask

	initial begin
		logic [67:0]                    directed[$];
		logic [fda_pkg::FRAC_CFG_W-1:0] cur_digits;
		logic [fda_pkg::FRAC_CFG_W-1:0] phase_digits;
		arst_n    = 1'b0;
		start     = 1'b0;
		value     = 64'd0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		cur_digits = 4'd2;

		// directed: {digit count, value}
		// reset digit count: zero, +/-1, extremes, small negative, fractions
		directed.push_back({4'd2, 64'h0000_0000_0000_0000});
		directed.push_back({4'd2, 64'h0000_0001_0000_0000});
		directed.push_back({4'd2, 64'hFFFF_FFFF_0000_0000});
		directed.push_back({4'd2, 64'h7FFF_FFFF_FFFF_FFFF});
		directed.push_back({4'd2, 64'h8000_0000_0000_0000});
		directed.push_back({4'd2, 64'hFFFF_FFFF_FFFF_FFFF});
		directed.push_back({4'd2, 64'h0000_0000_8000_0000});
		directed.push_back({4'd2, 64'h0000_0000_FFFF_FFFF});
		directed.push_back({4'd2, 64'h0000_007B_74BC_6A7E});
		directed.push_back({4'd2, 64'h0000_0000_0000_0001});
		directed.push_back({4'd2, 64'h0000_000A_0000_0000});
		directed.push_back({4'd2, 64'h5555_5555_AAAA_AAAA});
		// no point: zero gives the terminator alone, small negative gives '-'
		directed.push_back({4'd0, 64'h0000_0000_0000_0000});
		directed.push_back({4'd0, 64'hFFFF_FFFF_FFFF_FFFF});
		directed.push_back({4'd0, 64'h8000_0000_0000_0000});
		directed.push_back({4'd0, 64'h7FFF_FFFF_FFFF_FFFF});
		// widest text
		directed.push_back({4'd9, 64'h7FFF_FFFF_FFFF_FFFF});
		directed.push_back({4'd9, 64'h8000_0000_0000_0000});
		directed.push_back({4'd9, 64'h0000_0000_0000_0001});
		directed.push_back({4'd9, 64'hFFFF_FFFF_0000_0001});
		// digit count above the maximum saturates
		directed.push_back({4'd15, 64'h7FFF_FFFF_FFFF_FFFF});
		directed.push_back({4'd15, 64'h8000_0000_0000_0000});
		directed.push_back({4'd10, 64'hAAAA_AAAA_5555_5555});

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed[i]) begin
			if (directed[i][67:64] != cur_digits) begin
				wait_idle();
				cur_digits = directed[i][67:64];
				write_frac_digits(cur_digits);
			end
			send_value(directed[i][63:0], $urandom_range(0, 15));
		end

		// random phases, extremes of the digit count first
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: phase_digits = 4'd0;
				1: phase_digits = 4'd15;
				2: phase_digits = 4'd9;
				3: phase_digits = 4'd1;
				default: phase_digits = 4'($urandom_range(0, 15));
			endcase
			wait_idle();
			write_frac_digits(phase_digits);
			run_random_phase(54, (p == 2) || (p == 5));
		end

		wait_idle();
		repeat (END_SETTLE) @(posedge clk);
		sb.check_drained();
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
